@@ sv/barometric_pressure_compensation_top_assert.svh @@
// assertion macros for the pressure compensation top level
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_TOP_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define BPC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BPC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bpc_pkg.sv @@
// shared types and constants for the pressure compensation block
`default_nettype none

package bpc_pkg;

  localparam int ADDR_W = 5;
  localparam logic [1:0] OSS_RESET = 2'd3;

  typedef enum logic [1:0] {
    REG_OSS   = 2'd0,
    REG_CAL_A = 2'd1,
    REG_CAL_B = 2'd2,
    REG_CAL_C = 2'd3
  } reg_idx_t;

  // temperature path divider: |mc * 2048| over |x1 + md|
  localparam int DIV1_NW = 27;
  localparam int DIV1_DW = 19;
  // pressure path divider: 64 bit numerator over |b4|
  localparam int DIV2_NW = 64;
  localparam int DIV2_DW = 46;

  typedef struct packed {
    logic signed [18:0] x1a;
    logic [23:0]        up;
    logic               err;
    logic               qneg;
  } div1_side_t;

  typedef struct packed {
    logic signed [15:0] t;
    logic               err;
    logic               qneg;
    logic               post2;
  } div2_side_t;

  localparam int DIV1_SW = $bits(div1_side_t);
  localparam int DIV2_SW = $bits(div2_side_t);

  typedef struct packed {
    logic signed [31:0] pressure_pa;
    logic signed [15:0] temperature_tenths;
    logic               calc_error;
  } res_t;

endpackage

`default_nettype wire

@@ sv/bpc_if.sv @@
// item channels for raw samples and compensated results
`default_nettype none

interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [23:0] raw_pressure_bytes;

  modport source (output valid, raw_temperature, raw_pressure_bytes, input ready);
  modport sink (input valid, raw_temperature, raw_pressure_bytes, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pressure_pa;
  logic signed [15:0] temperature_tenths;
  logic               calc_error;

  modport source (output valid, pressure_pa, temperature_tenths, calc_error, input ready);
  modport sink (input valid, pressure_pa, temperature_tenths, calc_error, output ready);
endinterface

`default_nettype wire

@@ sv/bpc_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with sideband
`default_nettype none

module bpc_div #(
  parameter int NW = bpc_pkg::DIV1_NW,
  parameter int DW = bpc_pkg::DIV1_DW,
  parameter int SW = bpc_pkg::DIV1_SW
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_v,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_v,
  output logic [NW-1:0]      out_quo,
  output logic [SW-1:0]      out_side
);

  logic          v   [NW+1];
  logic [NW-1:0] nq  [NW+1];
  logic [SW-1:0] sd  [NW+1];
  logic [DW-1:0] rem [NW];
  logic [DW-1:0] dd  [NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq[0]  <= in_num;
      rem[0] <= '0;
      dd[0]  <= in_den;
      sd[0]  <= in_side;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic [DW:0] cat;
    logic [DW:0] sub;
    logic        ge;

    assign cat = {rem[k], nq[k][NW-1]};
    assign ge  = cat >= {1'b0, dd[k]};
    assign sub = cat - {1'b0, dd[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq[k+1] <= {nq[k][NW-2:0], ge};
        sd[k+1] <= sd[k];
      end
    end

    if (k < NW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= ge ? sub[DW-1:0] : cat[DW-1:0];
          dd[k+1]  <= dd[k];
        end
      end
    end
  end

  assign out_v    = v[NW];
  assign out_quo  = nq[NW];
  assign out_side = sd[NW];

endmodule

`default_nettype wire

@@ sv/barometric_pressure_compensation_top.sv @@
// pressure and temperature compensation top level with config port
// throughput: one item per cycle while the skid register is empty, set by the two divider
// pipelines (one stage per quotient bit)
// a result stalled at the output moves to a skid register; intake pauses only while it is full
// reset clears all valid bits and loads oversampling 3 and zero calibration
`default_nettype none

module barometric_pressure_compensation_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  bpc_in_if.sink                          samples,
  bpc_out_if.source                       results,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bpc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [63:0]                pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready
);

  // configuration registers
  logic [1:0]  oss;
  logic [47:0] cal_a;
  logic [47:0] cal_b;
  logic [63:0] cal_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      oss   <= bpc_pkg::OSS_RESET;
      cal_a <= '0;
      cal_b <= '0;
      cal_c <= '0;
    end else if (psel && penable && pwrite) begin
      case (bpc_pkg::reg_idx_t'(paddr[4:3]))
        bpc_pkg::REG_OSS:   oss   <= pwdata[1:0];
        bpc_pkg::REG_CAL_A: cal_a <= pwdata[47:0];
        bpc_pkg::REG_CAL_B: cal_b <= pwdata[47:0];
        bpc_pkg::REG_CAL_C: cal_c <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (bpc_pkg::reg_idx_t'(paddr[4:3]))
      bpc_pkg::REG_OSS:   prdata = {62'd0, oss};
      bpc_pkg::REG_CAL_A: prdata = {16'd0, cal_a};
      bpc_pkg::REG_CAL_B: prdata = {16'd0, cal_b};
      bpc_pkg::REG_CAL_C: prdata = cal_c;
      default:            prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;

  assign ac1 = cal_a[15:0];
  assign ac2 = cal_a[31:16];
  assign ac3 = cal_a[47:32];
  assign ac4 = cal_b[15:0];
  assign ac5 = cal_b[31:16];
  assign ac6 = cal_b[47:32];
  assign b1  = cal_c[15:0];
  assign b2  = cal_c[31:16];
  assign mc  = cal_c[47:32];
  assign md  = cal_c[63:48];

  // pipeline advance and output skid
  logic en;
  logic o_v, sk_v, fin_v;
  bpc_pkg::res_t o, sk, fin;

  assign en = !sk_v;
  assign samples.ready = en;

  // stage registers
  logic st0_v, st1_v, st2_v, st3_v, st4_v, st5_v, st6_v, st7_v, st8_v, st9_v, st10_v;
  logic st11_v;

  logic [15:0]        st0_ut;
  logic [23:0]        st0_up;
  logic signed [33:0] st1_prod;
  logic [23:0]        st1_up;

  logic signed [29:0] st2_b6;
  logic signed [15:0] st2_t;
  logic [23:0]        st2_up;
  logic               st2_err;

  logic signed [59:0] st3_sqf;
  logic signed [45:0] st3_ac2b6, st3_ac3b6;
  logic signed [15:0] st3_t;
  logic [23:0]        st3_up;
  logic               st3_err;

  logic signed [63:0] st4_b2sq, st4_b1sq;
  logic signed [45:0] st4_ac2b6, st4_ac3b6;
  logic signed [15:0] st4_t;
  logic [23:0]        st4_up;
  logic               st4_err;

  logic signed [57:0] st5_b3pre;
  logic signed [47:0] st5_x3b;
  logic signed [15:0] st5_t;
  logic [23:0]        st5_up;
  logic               st5_err;

  logic signed [55:0] st6_b3;
  logic signed [63:0] st6_b4prod;
  logic signed [15:0] st6_t;
  logic [23:0]        st6_up;
  logic               st6_err;

  logic signed [56:0] st7_diff;
  logic signed [45:0] st7_b4;
  logic signed [15:0] st7_t;
  logic               st7_err;

  logic signed [63:0] st8_b7;
  logic signed [45:0] st8_b4;
  logic signed [15:0] st8_t;
  logic               st8_err;

  logic signed [31:0] st9_p;
  logic signed [15:0] st9_t;
  logic               st9_err;

  logic signed [47:0] st10_sq2;
  logic signed [45:0] st10_m2;
  logic signed [31:0] st10_p;
  logic signed [15:0] st10_t;
  logic               st10_err;

  logic signed [44:0] st11_x1;
  logic signed [29:0] st11_x2;
  logic signed [31:0] st11_p;
  logic signed [15:0] st11_t;
  logic               st11_err;

  // input: oversampling shift
  logic [23:0] in_up;
  assign in_up = samples.raw_pressure_bytes >> (4'd8 - {2'b00, oss});

  // x1 product
  logic signed [16:0] c0_d;
  logic signed [33:0] c0_prod;
  assign c0_d    = signed'({1'b0, st0_ut}) - signed'({1'b0, ac6});
  assign c0_prod = 34'(c0_d) * 34'(signed'({1'b0, ac5}));

  // temperature divider operands
  logic signed [18:0] c1_x1a;
  logic signed [19:0] c1_den;
  logic signed [26:0] c1_num;
  logic [26:0]        c1_nmag;
  logic [18:0]        c1_dmag;
  bpc_pkg::div1_side_t c1_side;

  assign c1_x1a  = 19'(st1_prod >>> 15);
  assign c1_den  = 20'(c1_x1a) + 20'(md);
  assign c1_num  = signed'({mc, 11'b0});
  assign c1_nmag = c1_num[26] ? 27'(-c1_num) : 27'(c1_num);
  assign c1_dmag = c1_den[19] ? 19'(-c1_den) : 19'(c1_den);
  assign c1_side = '{x1a: c1_x1a, up: st1_up, err: (c1_den == 20'sd0),
                     qneg: c1_num[26] ^ c1_den[19]};

  logic                        d1_v;
  logic [bpc_pkg::DIV1_NW-1:0] d1_q;
  logic [bpc_pkg::DIV1_SW-1:0] d1_side;
  bpc_pkg::div1_side_t         d1s;

  bpc_div #(
    .NW(bpc_pkg::DIV1_NW),
    .DW(bpc_pkg::DIV1_DW),
    .SW(bpc_pkg::DIV1_SW)
  ) u_div_t (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (st1_v),
    .in_num   (c1_nmag),
    .in_den   (c1_dmag),
    .in_side  (c1_side),
    .out_v    (d1_v),
    .out_quo  (d1_q),
    .out_side (d1_side)
  );

  assign d1s = bpc_pkg::div1_side_t'(d1_side);

  // b5, temperature, b6
  logic signed [28:0] c2_x2;
  logic signed [29:0] c2_b5;
  logic signed [25:0] c2_t26;
  logic signed [15:0] c2_t;
  assign c2_x2  = d1s.qneg ? -signed'({2'b00, d1_q}) : signed'({2'b00, d1_q});
  assign c2_b5  = 30'(d1s.x1a) + 30'(c2_x2);
  assign c2_t26 = 26'((c2_b5 + 30'sd8) >>> 4);

  always_comb begin
    if (c2_t26 > 26'sd32767) begin
      c2_t = 16'sh7fff;
    end else if (c2_t26 < -26'sd32768) begin
      c2_t = 16'sh8000;
    end else begin
      c2_t = c2_t26[15:0];
    end
  end

  // b3 and b4 terms
  logic signed [47:0] c3_sq;
  assign c3_sq = 48'(st3_sqf >>> 12);

  logic signed [53:0] c4_x3;
  logic signed [57:0] c4_b3s;
  logic signed [47:0] c4_x3b;
  assign c4_x3  = 54'(st4_b2sq >>> 11) + 54'(st4_ac2b6 >>> 11);
  assign c4_b3s = 58'(signed'({ac1, 2'b00})) + 58'(c4_x3);
  assign c4_x3b = 48'((48'(st4_ac3b6 >>> 13) + 48'(st4_b1sq >>> 16) + 48'sd2) >>> 2);

  logic signed [55:0] c5_b3;
  assign c5_b3 = st5_b3pre[57] ? 56'((st5_b3pre + 58'sd3) >>> 2) : 56'(st5_b3pre >>> 2);

  logic signed [45:0] c6_b4;
  assign c6_b4 = 46'(st6_b4prod >>> 15);

  logic [15:0] c7_k;
  assign c7_k = 16'd50000 >> oss;

  // pressure divider operands
  logic               c8_lt;
  logic signed [63:0] c8_num;
  logic [63:0]        c8_nmag;
  logic [45:0]        c8_dmag;
  bpc_pkg::div2_side_t c8_side;

  assign c8_lt   = st8_b7 < 64'sd2147483648;
  assign c8_num  = c8_lt ? (st8_b7 <<< 1) : st8_b7;
  assign c8_nmag = c8_num[63] ? 64'(-c8_num) : 64'(c8_num);
  assign c8_dmag = st8_b4[45] ? 46'(-st8_b4) : 46'(st8_b4);
  assign c8_side = '{t: st8_t, err: st8_err, qneg: c8_num[63] ^ st8_b4[45], post2: !c8_lt};

  logic                        d2_v;
  logic [bpc_pkg::DIV2_NW-1:0] d2_q;
  logic [bpc_pkg::DIV2_SW-1:0] d2_side;
  bpc_pkg::div2_side_t         d2s;

  bpc_div #(
    .NW(bpc_pkg::DIV2_NW),
    .DW(bpc_pkg::DIV2_DW),
    .SW(bpc_pkg::DIV2_SW)
  ) u_div_p (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (st8_v),
    .in_num   (c8_nmag),
    .in_den   (c8_dmag),
    .in_side  (c8_side),
    .out_v    (d2_v),
    .out_quo  (d2_q),
    .out_side (d2_side)
  );

  assign d2s = bpc_pkg::div2_side_t'(d2_side);

  // quotient sign, doubling with wrap, int32 saturation
  logic [63:0]        c9_qv;
  logic signed [63:0] c9_qs;
  logic signed [31:0] c9_p;
  assign c9_qv = d2s.qneg ? 64'(-d2_q) : d2_q;
  assign c9_qs = signed'(d2s.post2 ? {c9_qv[62:0], 1'b0} : c9_qv);

  always_comb begin
    if (c9_qs > 64'sd2147483647) begin
      c9_p = 32'sh7fffffff;
    end else if (c9_qs < -64'sd2147483648) begin
      c9_p = 32'sh80000000;
    end else begin
      c9_p = c9_qs[31:0];
    end
  end

  // final correction terms
  logic signed [23:0] c10_ps;
  assign c10_ps = 24'(st9_p >>> 8);

  logic signed [47:0] c12_adj;
  logic signed [47:0] c12_pf;
  logic signed [31:0] c12_p;
  assign c12_adj = 48'((46'(st11_x1) + 46'(st11_x2) + 46'sd3791) >>> 4);
  assign c12_pf  = 48'(st11_p) + c12_adj;

  always_comb begin
    if (c12_pf > 48'sd2147483647) begin
      c12_p = 32'sh7fffffff;
    end else if (c12_pf < -48'sd2147483648) begin
      c12_p = 32'sh80000000;
    end else begin
      c12_p = c12_pf[31:0];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      st0_v  <= 1'b0;
      st1_v  <= 1'b0;
      st2_v  <= 1'b0;
      st3_v  <= 1'b0;
      st4_v  <= 1'b0;
      st5_v  <= 1'b0;
      st6_v  <= 1'b0;
      st7_v  <= 1'b0;
      st8_v  <= 1'b0;
      st9_v  <= 1'b0;
      st10_v <= 1'b0;
      st11_v <= 1'b0;
      fin_v  <= 1'b0;
    end else if (en) begin
      st0_v  <= samples.valid;
      st1_v  <= st0_v;
      st2_v  <= d1_v;
      st3_v  <= st2_v;
      st4_v  <= st3_v;
      st5_v  <= st4_v;
      st6_v  <= st5_v;
      st7_v  <= st6_v;
      st8_v  <= st7_v;
      st9_v  <= d2_v;
      st10_v <= st9_v;
      st11_v <= st10_v;
      fin_v  <= st11_v;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      st0_ut <= samples.raw_temperature;
      st0_up <= in_up;

      st1_prod <= c0_prod;
      st1_up   <= st0_up;

      st2_b6  <= c2_b5 - 30'sd4000;
      st2_t   <= c2_t;
      st2_up  <= d1s.up;
      st2_err <= d1s.err;

      st3_sqf   <= 60'(st2_b6) * 60'(st2_b6);
      st3_ac2b6 <= 46'(ac2) * 46'(st2_b6);
      st3_ac3b6 <= 46'(ac3) * 46'(st2_b6);
      st3_t     <= st2_t;
      st3_up    <= st2_up;
      st3_err   <= st2_err;

      st4_b2sq  <= 64'(b2) * 64'(c3_sq);
      st4_b1sq  <= 64'(b1) * 64'(c3_sq);
      st4_ac2b6 <= st3_ac2b6;
      st4_ac3b6 <= st3_ac3b6;
      st4_t     <= st3_t;
      st4_up    <= st3_up;
      st4_err   <= st3_err;

      st5_b3pre <= (c4_b3s <<< oss) + 58'sd2;
      st5_x3b   <= c4_x3b;
      st5_t     <= st4_t;
      st5_up    <= st4_up;
      st5_err   <= st4_err;

      st6_b3     <= c5_b3;
      st6_b4prod <= 64'(signed'({1'b0, ac4})) * 64'(st5_x3b + 48'sd32768);
      st6_t      <= st5_t;
      st6_up     <= st5_up;
      st6_err    <= st5_err;

      st7_diff <= 57'(signed'({1'b0, st6_up})) - 57'(st6_b3);
      st7_b4   <= c6_b4;
      st7_t    <= st6_t;
      st7_err  <= st6_err || (c6_b4 == 46'sd0);

      st8_b7  <= 64'(st7_diff) * 64'(signed'({1'b0, c7_k}));
      st8_b4  <= st7_b4;
      st8_t   <= st7_t;
      st8_err <= st7_err;

      st9_p   <= c9_p;
      st9_t   <= d2s.t;
      st9_err <= d2s.err;

      st10_sq2 <= 48'(c10_ps) * 48'(c10_ps);
      st10_m2  <= 46'(st9_p) * -46'sd7357;
      st10_p   <= st9_p;
      st10_t   <= st9_t;
      st10_err <= st9_err;

      st11_x1  <= 45'((61'(st10_sq2) * 61'sd3038) >>> 16);
      st11_x2  <= 30'(st10_m2 >>> 16);
      st11_p   <= st10_p;
      st11_t   <= st10_t;
      st11_err <= st10_err;

      fin.pressure_pa        <= st11_err ? 32'sd0 : c12_p;
      fin.temperature_tenths <= st11_err ? 16'sd0 : st11_t;
      fin.calc_error         <= st11_err;
    end
  end

  // output register and skid
  logic o_load, sk_load;
  assign o_load  = sk_v ? results.ready : (fin_v && (!o_v || results.ready));
  assign sk_load = !sk_v && fin_v && o_v && !results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v  <= 1'b0;
      sk_v <= 1'b0;
    end else begin
      if (o_load) begin
        o_v <= 1'b1;
      end else if (results.ready) begin
        o_v <= 1'b0;
      end
      if (sk_load) begin
        sk_v <= 1'b1;
      end else if (results.ready) begin
        sk_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o <= sk_v ? sk : fin;
    end
    if (sk_load) begin
      sk <= fin;
    end
  end

  assign results.valid              = o_v;
  assign results.pressure_pa        = o.pressure_pa;
  assign results.temperature_tenths = o.temperature_tenths;
  assign results.calc_error         = o.calc_error;

`include "barometric_pressure_compensation_top_assert.svh"

  `BPC_ASSERT_NOW(a_skid_needs_out, sk_v, o_v, "skid holds an item while output is empty")
  `BPC_ASSERT_NEXT(a_stall_fills_skid, fin_v && !sk_v && o_v && !results.ready, sk_v, "stalled item not caught by skid")
  `BPC_ASSERT_NOW(a_err_zeroes, o_v && o.calc_error, (o.pressure_pa == 32'sd0) && (o.temperature_tenths == 16'sd0), "error result not zeroed")

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// pressure compensation testbench: directed and random samples checked against a predictor
`timescale 1ns / 1ps
`default_nettype none

module testbench;

  typedef struct packed {
    logic [15:0] ut;
    logic [23:0] pb;
  } sample_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [bpc_pkg::ADDR_W-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  bpc_in_if samples ();
  bpc_out_if results ();

  barometric_pressure_compensation_top DUT (
    .clk(clk), .rst(rst), .samples(samples.sink), .results(results.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [1:0] oss_cfg;
  logic [47:0] cal_a;
  logic [47:0] cal_b;
  logic [63:0] cal_c;

  sample_t pending_samples[$];
  bpc_pkg::res_t expected_readings[$];
  int errors;
  bit quiet;
  bit hold_go;
  bit hold_out;
  logic took_in;
  logic took_out;
  int in_gap;
  int out_wait;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bpc_pkg::res_t compensate(logic [15:0] ut_raw, logic [23:0] pb);
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, t, den, sq;
    bpc_pkg::res_t r;
    ac1 = longint'($signed(cal_a[15:0]));
    ac2 = longint'($signed(cal_a[31:16]));
    ac3 = longint'($signed(cal_a[47:32]));
    ac4 = longint'(cal_b[15:0]);
    ac5 = longint'(cal_b[31:16]);
    ac6 = longint'(cal_b[47:32]);
    b1 = longint'($signed(cal_c[15:0]));
    b2 = longint'($signed(cal_c[31:16]));
    mc = longint'($signed(cal_c[47:32]));
    md = longint'($signed(cal_c[63:48]));
    ut = longint'(ut_raw);
    up = longint'(pb >> (8 - oss_cfg));
    r = '0;
    r.calc_error = 1'b1;
    x1 = ((ut - ac6) * ac5) >>> 15;
    den = x1 + md;
    if (den == 0) return r;
    x2 = (mc * 2048) / den;
    b5 = x1 + x2;
    t = clip((b5 + 8) >>> 4, -32768, 32767);
    b6 = b5 - 4000;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << oss_cfg) + 2) / 4;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    b4 = (ac4 * (x3 + 32768)) >>> 15;
    if (b4 == 0) return r;
    b7 = (up - b3) * longint'(50000 >> oss_cfg);
    if (b7 < 64'sh80000000) p = (b7 * 2) / b4;
    else p = (b7 / b4) * 2;
    p = clip(p, -64'sd2147483648, 64'sd2147483647);
    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * 3038) >>> 16;
    x2 = (-7357 * p) >>> 16;
    p = clip(p + ((x1 + x2 + 3791) >>> 4), -64'sd2147483648, 64'sd2147483647);
    r.pressure_pa = p[31:0];
    r.temperature_tenths = t[15:0];
    r.calc_error = 1'b0;
    return r;
  endfunction

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  task automatic write_reg(bpc_pkg::reg_idx_t idx, logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      bpc_pkg::REG_OSS: oss_cfg = value[1:0];
      bpc_pkg::REG_CAL_A: cal_a = value[47:0];
      bpc_pkg::REG_CAL_B: cal_b = value[47:0];
      default: cal_c = value;
    endcase
  endtask

  task automatic configure(logic [1:0] oss, logic [47:0] a, logic [47:0] b, logic [63:0] c);
    write_reg(bpc_pkg::REG_OSS, {62'd0, oss});
    write_reg(bpc_pkg::REG_CAL_A, {16'd0, a});
    write_reg(bpc_pkg::REG_CAL_B, {16'd0, b});
    write_reg(bpc_pkg::REG_CAL_C, c);
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
      #1;
    end while (pending_samples.size() != 0 || samples.valid || expected_readings.size() != 0);
  endtask

  // datasheet-like calibration with random spread
  task automatic plausible_config(logic [1:0] oss);
    configure(oss,
      {16'(-14383 + $urandom_range(0, 2000) - 1000), 16'(-72 + $urandom_range(0, 200) - 100),
       16'(408 + $urandom_range(0, 8000) - 4000)},
      {16'(23153 + $urandom_range(0, 4000) - 2000), 16'(32757 - $urandom_range(0, 4000)),
       16'(32741 - $urandom_range(0, 4000))},
      {16'(2868 + $urandom_range(0, 1000) - 500), 16'(-8711 + $urandom_range(0, 2000) - 1000),
       16'($urandom_range(0, 40)), 16'(6190 + $urandom_range(0, 1000) - 500)});
  endtask

  task automatic random_items(int n, bit plausible);
    sample_t s;
    for (int i = 0; i < n; i++) begin
      if (plausible && $urandom_range(0, 3) != 0) begin
        s.ut = 16'($urandom_range(20000, 36000));
        s.pb = 24'($urandom_range(5000, 40000) << 8) | 24'($urandom_range(0, 255));
      end else begin
        s.ut = 16'($urandom);
        s.pb = 24'($urandom);
      end
      pending_samples.push_back(s);
    end
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      samples.valid <= 1'b0;
      in_gap <= 0;
    end else if (samples.valid && !took_in) begin
    end else if (in_gap > 0) begin
      samples.valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (pending_samples.size() != 0 && !(samples.valid && draw_wait() > 6 && !quiet)) begin
      samples.valid <= 1'b1;
      samples.raw_temperature <= pending_samples[0].ut;
      samples.raw_pressure_bytes <= pending_samples[0].pb;
      void'(pending_samples.pop_front());
      in_gap <= draw_wait();
    end else begin
      samples.valid <= 1'b0;
      in_gap <= draw_wait();
    end
  end

  // receiver
  always @(negedge clk) begin
    int w;
    w = draw_wait();
    if (rst) begin
      results.ready <= 1'b0;
      out_wait <= 0;
    end else if (hold_out) begin
      results.ready <= 1'b0;
    end else if (took_out) begin
      if (w > 0) begin
        out_wait <= w - 1;
        results.ready <= 1'b0;
      end else begin
        out_wait <= 0;
        results.ready <= 1'b1;
      end
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      results.ready <= 1'b0;
    end else begin
      results.ready <= 1'b1;
    end
  end

  // long receiver hold-off
  initial begin
    hold_out = 1'b0;
    wait (hold_go);
    @(negedge clk);
    hold_out = 1'b1;
    repeat (400) @(posedge clk);
    @(negedge clk);
    hold_out = 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    bpc_pkg::res_t want;
    took_in <= samples.valid && samples.ready && !rst;
    took_out <= results.valid && results.ready && !rst;
    if (!rst && samples.valid && samples.ready)
      expected_readings.push_back(compensate(samples.raw_temperature, samples.raw_pressure_bytes));
    if (!rst && results.valid && results.ready) begin
      if (expected_readings.size() == 0) begin
        report("unexpected item", results.pressure_pa, 0);
      end else begin
        want = expected_readings.pop_front();
        if (results.pressure_pa !== want.pressure_pa)
          report("pressure_pa", results.pressure_pa, want.pressure_pa);
        if (results.temperature_tenths !== want.temperature_tenths)
          report("temperature_tenths", 32'(results.temperature_tenths), 32'(want.temperature_tenths));
        if (results.calc_error !== want.calc_error)
          report("calc_error", 32'(results.calc_error), 32'(want.calc_error));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= 5000) begin
      $display("** barometric_pressure_compensation_top: FAILED **");
      $finish;
    end
  end

  initial begin
    sample_t s;
    errors = 0;
    quiet = 1'b0;
    hold_go = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    oss_cfg = bpc_pkg::OSS_RESET;
    cal_a = '0;
    cal_b = '0;
    cal_c = '0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset calibration: every item hits the zero divisor
    pending_samples.push_back('{16'h0000, 24'h000000});
    pending_samples.push_back('{16'hffff, 24'hffffff});
    wait_idle();

    // datasheet example at each oversampling setting
    for (int o = 0; o < 4; o++) begin
      configure(2'(o), {16'hc7d1, 16'hffb8, 16'd408}, {16'd23153, 16'd32757, 16'd32741},
                {16'd2868, 16'hddf9, 16'd4, 16'd6190});
      pending_samples.push_back('{16'd27898, 24'(23843 << (8 - o))});
      pending_samples.push_back('{16'h0000, 24'h000000});
      pending_samples.push_back('{16'hffff, 24'hffffff});
      wait_idle();
    end
    // zero divisor through md, zero divisor through b4
    configure(2'd0, 48'd0, 48'd0, {16'd0, 16'd5, 16'd0, 16'd0});
    pending_samples.push_back('{16'd1234, 24'h123456});
    wait_idle();
    configure(2'd3, 48'd0, {16'd0, 16'd0, 16'd0}, {16'd1, 16'd100, 16'd0, 16'd0});
    pending_samples.push_back('{16'd30000, 24'h400000});
    wait_idle();
    // temperature saturation both ways
    configure(2'd3, 48'd0, {16'd0, 16'd0, 16'd1000}, {16'd1, 16'h8000, 16'd0, 16'd0});
    pending_samples.push_back('{16'd0, 24'h000000});
    pending_samples.push_back('{16'hffff, 24'hffffff});
    wait_idle();
    configure(2'd2, 48'd0, {16'd0, 16'd0, 16'd1000}, {16'd1, 16'h7fff, 16'd0, 16'd0});
    pending_samples.push_back('{16'd0, 24'hffffff});
    wait_idle();
    // large b7 taking the divide-then-double path, and all-ones calibration
    configure(2'd0, {16'd0, 16'd0, 16'h8000}, {16'd0, 16'd0, 16'd1}, {16'd1, 16'd0, 16'd0, 16'd0});
    pending_samples.push_back('{16'd0, 24'hffffff});
    wait_idle();
    configure(2'd3, 48'hffffffffffff, 48'hffffffffffff, 64'hffffffffffffffff);
    pending_samples.push_back('{16'hffff, 24'hffffff});
    pending_samples.push_back('{16'h0000, 24'h000001});
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      quiet = (ph % 4 == 3) || (ph == 4);
      if (ph % 3 == 2)
        configure(2'($urandom), 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                  {$urandom, $urandom});
      else
        plausible_config(2'(ph % 4));
      if (ph == 4) begin
        hold_go = 1'b1;
        random_items(250, 1'b1);
      end else if (ph == 7) begin
        random_items(30, 1'b1);
        wait_idle();
        random_items(40, 1'b1);
      end else begin
        random_items(60, ph % 3 != 2);
      end
      wait_idle();
    end
    quiet = 1'b0;

    repeat (150) @(posedge clk);
    if (errors == 0 && expected_readings.size() == 0) begin
      $display("** barometric_pressure_compensation_top: PASSED **");
    end else begin
      $display("** barometric_pressure_compensation_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/bpc_pkg.sv
sv/bpc_if.sv
sv/bpc_div.sv
sv/barometric_pressure_compensation_top.sv
sim/testbench.sv
